// ===== design/dasc_pkg.sv =====
// ----------------------------------------------------------------------------
// Door access session controller package
// Shared types, command and status codes, and reset constants.
// ----------------------------------------------------------------------------
package dasc_pkg;

  // Widths of the transaction fields
  localparam int unsigned CmdW    = 4;
  localparam int unsigned UidW    = 56;
  localparam int unsigned UidLenW = 3;
  localparam int unsigned TickW   = 32;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 32;

  // Number of UID bytes that the controller keeps, clamped to the field width
  localparam int unsigned UID_BYTES   = 7;
  localparam int unsigned UidFieldMax = UidW / 8;
  localparam int unsigned UID_CAP     = (UID_BYTES > UidFieldMax) ? UidFieldMax : UID_BYTES;

  // Configuration register indices and reset values
  localparam logic [CfgIdxW-1:0] REG_SESSION_DURATION = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_AUTH_WAIT        = 1'b1;
  localparam logic [TickW-1:0]   SESSION_DURATION_RST = 32'd3600000;
  localparam logic [TickW-1:0]   AUTH_WAIT_RST        = 32'd10000;

  // Door state
  typedef enum logic [1:0] {
    MODE_LOCKED = 2'd0,
    MODE_WAIT   = 2'd1,
    MODE_OPEN   = 2'd2
  } mode_e;

  // Incoming events
  typedef enum logic [CmdW-1:0] {
    CMD_TICK            = 4'd0,
    CMD_CARD_READ       = 4'd1,
    CMD_GRANTED         = 4'd2,
    CMD_DENIED          = 4'd3,
    CMD_AUTH_TIMEOUT    = 4'd4,
    CMD_UNLOCK_REQ      = 4'd5,
    CMD_OVERRIDE_ENGAGE = 4'd6,
    CMD_OVERRIDE_OFF    = 4'd7,
    CMD_PRESENCE_ON     = 4'd8,
    CMD_PRESENCE_OFF    = 4'd9,
    CMD_SET_PRESENCE    = 4'd10,
    CMD_SET_OVERRIDE    = 4'd11,
    CMD_CANCEL          = 4'd12
  } cmd_e;

  // Lock actuator pulse
  typedef enum logic [1:0] {
    DRIVE_NONE   = 2'd0,
    DRIVE_UNLOCK = 2'd1,
    DRIVE_LOCK   = 2'd2
  } drive_e;

  // Access outcome
  typedef enum logic [1:0] {
    RESULT_NONE     = 2'd0,
    RESULT_SUCCESS  = 2'd1,
    RESULT_REJECTED = 2'd2,
    RESULT_TIMEOUT  = 2'd3
  } result_e;

  // One input transaction
  typedef struct packed {
    logic [CmdW-1:0]    command;
    logic [UidW-1:0]    card_uid;
    logic [UidLenW-1:0] card_uid_length;
    logic               level;
  } item_t;

  // One result transaction
  typedef struct packed {
    mode_e              door_state;
    drive_e             lock_drive;
    result_e            auth_status;
    logic               session_on;
    logic               override_active;
    logic               presence_on;
    logic [UidW-1:0]    held_uid;
    logic [UidLenW-1:0] held_uid_length;
  } res_t;

  // Configuration register contents
  typedef struct packed {
    logic [TickW-1:0] session_duration;
    logic [TickW-1:0] auth_wait;
  } cfg_t;

endpackage

// ===== design/door_access_session_controller_unit.sv =====
// Path: input register, control stage, then result register once it has room.
// Throughput: one transaction per cycle while the consumer takes results; the
// state update and the counter compares for a transaction sit in a single
// pass of the control stage.
// Reset: door locked, counters, flags and held UID cleared, configuration
// registers back to their default durations; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Door access session controller
// Event and tick driven door controller with session and authorisation timing.
// ----------------------------------------------------------------------------
module door_access_session_controller_unit import dasc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  // Input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CmdW-1:0]    command_i,
  input  logic [UidW-1:0]    card_uid_i,
  input  logic [UidLenW-1:0] card_uid_length_i,
  input  logic               level_i,
  // Result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         door_state_o,
  output logic [1:0]         lock_drive_o,
  output logic [1:0]         auth_status_o,
  output logic               session_on_o,
  output logic               override_active_o,
  output logic               presence_on_o,
  output logic [UidW-1:0]    held_uid_o,
  output logic [UidLenW-1:0] held_uid_length_o
);

  cfg_t  cfg_q;
  item_t in_item, stage_item;
  logic  stage_valid, advance;
  res_t  ctrl_res, out_res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.session_duration <= SESSION_DURATION_RST;
      cfg_q.auth_wait        <= AUTH_WAIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SESSION_DURATION: cfg_q.session_duration <= cfg_wdata_i;
        REG_AUTH_WAIT:        cfg_q.auth_wait        <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Input transaction bundle
  always_comb begin
    in_item.command         = command_i;
    in_item.card_uid        = card_uid_i;
    in_item.card_uid_length = card_uid_length_i;
    in_item.level           = level_i;
  end

  dasc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .valid_o    (stage_valid),
    .advance_i  (advance),
    .item_o     (stage_item)
  );

  dasc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (stage_item),
    .cfg_i  (cfg_q),
    .res_o  (ctrl_res)
  );

  dasc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .src_valid_i (stage_valid),
    .advance_o   (advance),
    .res_i       (ctrl_res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  // Result fields
  assign door_state_o      = out_res.door_state;
  assign lock_drive_o      = out_res.lock_drive;
  assign auth_status_o     = out_res.auth_status;
  assign session_on_o      = out_res.session_on;
  assign override_active_o = out_res.override_active;
  assign presence_on_o     = out_res.presence_on;
  assign held_uid_o        = out_res.held_uid;
  assign held_uid_length_o = out_res.held_uid_length;

`ifndef ASSERT_OFF
  // An unlock pulse always comes with the door open
  a_unlock_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && lock_drive_o == DRIVE_UNLOCK) |-> door_state_o == MODE_OPEN)
    else $error("unlock pulse without open door");

  // A lock pulse ends the session and locks the door
  a_lock_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && lock_drive_o == DRIVE_LOCK) |->
      (door_state_o == MODE_LOCKED && !session_on_o))
    else $error("lock pulse with session still active");

  // A successful grant leaves an open door with an active session
  a_success_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && auth_status_o == RESULT_SUCCESS) |->
      (door_state_o == MODE_OPEN && session_on_o))
    else $error("success reported without open session");

  // With the result register empty the input side never stalls
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while result register empty");
`endif

endmodule

// ===== design/dasc_in_reg.sv =====
// ----------------------------------------------------------------------------
// Door access input register
// Holds one accepted transaction until the control stage takes it.
// ----------------------------------------------------------------------------
module dasc_in_reg import dasc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t item_i,
  output logic  valid_o,
  input  logic  advance_i,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  // Room for a new transaction when empty or when the held one moves on
  assign in_ready_o = !valid_q || advance_i;

  // Occupancy flag
  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== design/dasc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Door access control stage
// Door state machine, tick counters, flags and UID capture for one transaction.
// ----------------------------------------------------------------------------
module dasc_ctrl import dasc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  mode_e              mode_q, mode_d;
  logic [TickW-1:0]   session_ticks_q, session_ticks_d;
  logic [TickW-1:0]   auth_ticks_q, auth_ticks_d;
  logic               presence_q, presence_d;
  logic               override_q, override_d;
  logic               session_q, session_d;
  logic [UidW-1:0]    uid_q, uid_d;
  logic [UidLenW-1:0] uid_len_q, uid_len_d;

  cmd_e               cmd;
  logic               locked, waiting, open;
  logic [TickW-1:0]   session_inc, auth_inc;
  logic               session_expire, auth_expire;
  logic [UidLenW-1:0] cap_len;
  logic [UidW-1:0]    uid_merged;
  drive_e             drive;
  result_e            result;

  assign cmd     = cmd_e'(item_i.command);
  assign locked  = (mode_q == MODE_LOCKED);
  assign waiting = (mode_q == MODE_WAIT);
  assign open    = (mode_q == MODE_OPEN);

  // Saturating counters and their expiry compares
  assign session_inc    = (session_ticks_q == '1) ? session_ticks_q : session_ticks_q + 1'b1;
  assign auth_inc       = (auth_ticks_q == '1) ? auth_ticks_q : auth_ticks_q + 1'b1;
  assign session_expire = !override_q && !presence_q && (session_inc >= cfg_i.session_duration);
  assign auth_expire    = (auth_inc >= cfg_i.auth_wait);

  // UID capture: the low bytes come from the card, the rest are kept
  assign cap_len = (item_i.card_uid_length > UidLenW'(UID_CAP)) ? UidLenW'(UID_CAP)
                                                                 : item_i.card_uid_length;
  always_comb begin
    uid_merged = uid_q;
    for (int b = 0; b < UidFieldMax; b++) begin
      if (UidLenW'(b) < cap_len) begin
        uid_merged[8*b +: 8] = item_i.card_uid[8*b +: 8];
      end
    end
  end

  // Next state
  always_comb begin
    mode_d          = mode_q;
    session_ticks_d = session_ticks_q;
    auth_ticks_d    = auth_ticks_q;
    presence_d      = presence_q;
    override_d      = override_q;
    session_d       = session_q;
    uid_d           = uid_q;
    uid_len_d       = uid_len_q;
    unique case (cmd)
      CMD_TICK: begin
        if (open) begin
          session_ticks_d = session_inc;
          if (session_expire) begin
            session_d = 1'b0;
            mode_d    = MODE_LOCKED;
          end
        end else if (waiting) begin
          auth_ticks_d = auth_inc;
          if (auth_expire) begin
            mode_d = MODE_LOCKED;
          end
        end
      end
      CMD_CARD_READ: begin
        if (locked || waiting) begin
          auth_ticks_d = '0;
          mode_d       = MODE_WAIT;
          if (cap_len != '0) begin
            uid_d     = uid_merged;
            uid_len_d = cap_len;
          end
        end
      end
      CMD_GRANTED: begin
        if (locked || waiting) begin
          session_d       = 1'b1;
          session_ticks_d = '0;
          mode_d          = MODE_OPEN;
        end
      end
      CMD_DENIED, CMD_AUTH_TIMEOUT, CMD_CANCEL: begin
        if (waiting) begin
          mode_d = MODE_LOCKED;
        end
      end
      CMD_UNLOCK_REQ: begin
        if (locked) begin
          session_d       = 1'b1;
          session_ticks_d = '0;
          mode_d          = MODE_OPEN;
        end
      end
      CMD_OVERRIDE_ENGAGE: begin
        if (locked) begin
          override_d      = 1'b1;
          session_d       = 1'b1;
          session_ticks_d = '0;
          mode_d          = MODE_OPEN;
        end else if (open) begin
          override_d = 1'b1;
        end
      end
      CMD_OVERRIDE_OFF: begin
        if (open) begin
          override_d = 1'b0;
        end
      end
      CMD_PRESENCE_ON: begin
        if (!waiting) begin
          presence_d = 1'b1;
        end
      end
      CMD_PRESENCE_OFF: begin
        if (!waiting) begin
          presence_d = 1'b0;
        end
      end
      CMD_SET_PRESENCE: begin
        presence_d = item_i.level;
      end
      CMD_SET_OVERRIDE: begin
        override_d = item_i.level;
        if (item_i.level && locked) begin
          session_ticks_d = '0;
          mode_d          = MODE_OPEN;
        end
      end
      default: begin
      end
    endcase
  end

  // Pulse and status outputs
  always_comb begin
    drive  = DRIVE_NONE;
    result = RESULT_NONE;
    unique case (cmd)
      CMD_TICK: begin
        if (open && session_expire) begin
          drive = DRIVE_LOCK;
        end else if (waiting && auth_expire) begin
          result = RESULT_TIMEOUT;
        end
      end
      CMD_GRANTED: begin
        if (locked || waiting) begin
          drive = DRIVE_UNLOCK;
        end
        if (waiting) begin
          result = RESULT_SUCCESS;
        end
      end
      CMD_DENIED: begin
        if (waiting) begin
          result = RESULT_REJECTED;
        end
      end
      CMD_AUTH_TIMEOUT: begin
        if (waiting) begin
          result = RESULT_TIMEOUT;
        end
      end
      CMD_UNLOCK_REQ, CMD_OVERRIDE_ENGAGE: begin
        if (locked) begin
          drive = DRIVE_UNLOCK;
        end
      end
      CMD_SET_OVERRIDE: begin
        if (item_i.level && locked) begin
          drive = DRIVE_UNLOCK;
        end
      end
      default: begin
      end
    endcase
  end

  // State registers, updated once per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q          <= MODE_LOCKED;
      session_ticks_q <= '0;
      auth_ticks_q    <= '0;
      presence_q      <= 1'b0;
      override_q      <= 1'b0;
      session_q       <= 1'b0;
      uid_q           <= '0;
      uid_len_q       <= '0;
    end else if (step_i) begin
      mode_q          <= mode_d;
      session_ticks_q <= session_ticks_d;
      auth_ticks_q    <= auth_ticks_d;
      presence_q      <= presence_d;
      override_q      <= override_d;
      session_q       <= session_d;
      uid_q           <= uid_d;
      uid_len_q       <= uid_len_d;
    end
  end

  // Result shows the state after the transaction
  always_comb begin
    res_o.door_state      = mode_d;
    res_o.lock_drive      = drive;
    res_o.auth_status     = result;
    res_o.session_on      = session_d;
    res_o.override_active = override_d;
    res_o.presence_on     = presence_d;
    res_o.held_uid        = uid_d;
    res_o.held_uid_length = uid_len_d;
  end

endmodule

// ===== design/dasc_out_reg.sv =====
// ----------------------------------------------------------------------------
// Door access result register
// Holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module dasc_out_reg import dasc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic src_valid_i,
  output logic advance_o,
  input  res_t res_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  // Load when empty or when the held result leaves in the same cycle
  assign advance_o = src_valid_i && (!valid_q || out_ready_i);

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register
  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule
